>>> hw/rtl/fmws_pkg.sv
// Shared types and constants for the FM chip write shadow and mute sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
package fmws_pkg;

   localparam int OP_W   = 4;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 5;
   localparam int KIND_W = 3;
   localparam int MASK_W = 32;
   localparam int NCH    = 8;
   localparam int NLEVEL = 32;

   // Operation codes of the request word.
   localparam logic [OP_W-1:0] OP_WRITE      = 4'd0;
   localparam logic [OP_W-1:0] OP_KEYOFF     = 4'd1;
   localparam logic [OP_W-1:0] OP_LEVEL_MUTE = 4'd2;
   localparam logic [OP_W-1:0] OP_OUT_OFF    = 4'd3;
   localparam logic [OP_W-1:0] OP_ALL_MUTE   = 4'd4;
   localparam logic [OP_W-1:0] OP_KEYON      = 4'd5;
   localparam logic [OP_W-1:0] OP_LEVEL_REST = 4'd6;
   localparam logic [OP_W-1:0] OP_OUT_ON     = 4'd7;
   localparam logic [OP_W-1:0] OP_ALL_UNMUTE = 4'd8;

   // Kinds of emitted chip writes.
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_KEYOFF = 3'd1;
   localparam logic [KIND_W-1:0] KIND_KEYON  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LMUTE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LREST  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OOFF   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_OON    = 3'd6;

   // Chip register addresses and data constants.
   localparam logic [BYTE_W-1:0] ADDR_KEYON = 8'h08;
   localparam logic [BYTE_W-1:0] ADDR_PAN   = 8'h20;
   localparam logic [BYTE_W-1:0] ADDR_LEVEL = 8'h60;
   localparam logic [BYTE_W-1:0] KEYON_ALL  = 8'h78;
   localparam logic [BYTE_W-1:0] LEVEL_MAX  = 8'h7F;
   localparam logic [BYTE_W-1:0] PAN_OFF    = 8'h3F;
   localparam logic [BYTE_W-1:0] PAN_ON     = 8'hC0;

   localparam logic [IDX_W-1:0] LAST_CH    = 5'd7;
   localparam logic [IDX_W-1:0] LAST_LEVEL = 5'd31;

   typedef struct packed {
      logic              emit;
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/fmws_ctrl.sv
// Controller of the write sequencer: accepts request words and steps through sequences.
// Depends on fmws_pkg.
module fmws_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fmws_pkg::OP_W-1:0]     req_operation,
   input  fmws_pkg::dp_status_type       status,
   output fmws_pkg::ctrl_cmd_type        cmd
);
   import fmws_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              chain_ff, chain_in;
   logic              seq_end;

   // No word is taken while reset is held.
   assign req_ready = !reset && (state_ff == ST_IDLE) && status.out_free;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      chain_in = chain_ff;
      cmd      = '0;
      seq_end  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               idx_in   = '0;
               chain_in = 1'b0;
               state_in = ST_RUN;
               case (req_operation)
                  OP_WRITE: begin
                     cmd.emit = 1'b1;
                     cmd.kind = KIND_WRITE;
                     cmd.last = 1'b1;
                     state_in = ST_IDLE;
                  end
                  OP_KEYOFF:     kind_in = KIND_KEYOFF;
                  OP_LEVEL_MUTE: kind_in = KIND_LMUTE;
                  OP_OUT_OFF:    kind_in = KIND_OOFF;
                  OP_ALL_MUTE: begin
                     kind_in  = KIND_LMUTE;
                     chain_in = 1'b1;
                  end
                  OP_KEYON:      kind_in = KIND_KEYON;
                  OP_LEVEL_REST: kind_in = KIND_LREST;
                  OP_OUT_ON:     kind_in = KIND_OON;
                  OP_ALL_UNMUTE: begin
                     kind_in  = KIND_LREST;
                     chain_in = 1'b1;
                  end
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               if (kind_ff == KIND_LMUTE || kind_ff == KIND_LREST) begin
                  seq_end = (idx_ff == LAST_LEVEL);
               end else begin
                  seq_end = (idx_ff == LAST_CH);
               end
               cmd.emit = 1'b1;
               cmd.kind = kind_ff;
               cmd.idx  = idx_ff;
               cmd.last = seq_end && !chain_ff;
               if (seq_end) begin
                  idx_in = '0;
                  if (chain_ff) begin
                     chain_in = 1'b0;
                     kind_in  = (kind_ff == KIND_LMUTE) ? KIND_OOFF : KIND_OON;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_WRITE;
         idx_ff   <= '0;
         chain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

endmodule

>>> hw/rtl/fmws_dp.sv
// Datapath of the write sequencer: shadow registers, word formation and output register.
// Depends on fmws_pkg.
module fmws_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fmws_pkg::ctrl_cmd_type          cmd,
   input  logic [fmws_pkg::BYTE_W-1:0]     req_reg_address,
   input  logic [fmws_pkg::BYTE_W-1:0]     req_reg_value,
   output fmws_pkg::dp_status_type         status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fmws_pkg::BYTE_W-1:0]     rsp_bus_address,
   output logic [fmws_pkg::BYTE_W-1:0]     rsp_bus_data,
   output logic                            rsp_last,
   output logic [fmws_pkg::MASK_W-1:0]     rsp_keyon_masks
);
   import fmws_pkg::*;

   logic [BYTE_W-1:0] pan_ff   [NCH];
   logic [BYTE_W-1:0] pan_in   [NCH];
   logic [3:0]        keyon_ff [NCH];
   logic [3:0]        keyon_in [NCH];
   logic [BYTE_W-1:0] level_ff [NLEVEL];
   logic [BYTE_W-1:0] level_in [NLEVEL];

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic [MASK_W-1:0] masks_ff, masks_in;
   logic              level_hold;

   assign status.out_free = !valid_ff || rsp_ready;

   // Form the chip write for this cycle.
   always_comb begin
      addr_in = req_reg_address;
      data_in = req_reg_value;
      case (cmd.kind)
         KIND_WRITE: begin
            addr_in = req_reg_address;
            data_in = req_reg_value;
         end
         KIND_KEYOFF: begin
            addr_in = ADDR_KEYON;
            data_in = {5'b0, cmd.idx[2:0]};
         end
         KIND_KEYON: begin
            addr_in = ADDR_KEYON;
            data_in = KEYON_ALL | {5'b0, cmd.idx[2:0]};
         end
         KIND_LMUTE: begin
            addr_in = ADDR_LEVEL + {3'b0, cmd.idx};
            data_in = LEVEL_MAX;
         end
         KIND_LREST: begin
            addr_in = ADDR_LEVEL + {3'b0, cmd.idx};
            data_in = level_ff[cmd.idx];
         end
         KIND_OOFF: begin
            addr_in = ADDR_PAN + {3'b0, cmd.idx};
            data_in = pan_ff[cmd.idx[2:0]] & PAN_OFF;
         end
         KIND_OON: begin
            addr_in = ADDR_PAN + {3'b0, cmd.idx};
            data_in = pan_ff[cmd.idx[2:0]] | PAN_ON;
         end
         default: begin
            addr_in = req_reg_address;
            data_in = req_reg_value;
         end
      endcase
   end

   assign level_hold = (cmd.kind == KIND_LMUTE);

   // Shadow update applied to every emitted write; level mute writes leave the level shadow unchanged.
   always_comb begin
      pan_in   = pan_ff;
      keyon_in = keyon_ff;
      level_in = level_ff;
      if (cmd.emit) begin
         if (addr_in[7:3] == ADDR_PAN[7:3]) begin
            pan_in[addr_in[2:0]] = data_in;
         end
         if (addr_in == ADDR_KEYON) begin
            keyon_in[data_in[2:0]] = data_in[6:3];
         end
         if (addr_in[7:5] == ADDR_LEVEL[7:5] && !level_hold) begin
            level_in[addr_in[4:0]] = data_in;
         end
      end
   end

   always_comb begin
      masks_in = '0;
      for (int ch = 0; ch < NCH; ch++) begin
         masks_in[4*ch +: 4] = keyon_in[ch];
      end
   end

   assign last_in  = cmd.last;
   assign valid_in = cmd.emit || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < NCH; i++) begin
            pan_ff[i]   <= '0;
            keyon_ff[i] <= '0;
         end
         for (int i = 0; i < NLEVEL; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         pan_ff   <= pan_in;
         keyon_ff <= keyon_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         last_ff  <= last_in;
         masks_ff <= masks_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_bus_address = addr_ff;
   assign rsp_bus_data    = data_ff;
   assign rsp_last        = last_ff;
   assign rsp_keyon_masks = masks_ff;

endmodule

>>> hw/rtl/fm_chip_write_shadow_mute_sequencer_core.sv
// Top level of the FM chip write shadow and mute sequencer.
// Depends on fmws_pkg, fmws_ctrl and fmws_dp.
//
// Usage: each request word carries an operation and, for a plain write, a chip
// register address and data byte. The block answers with one response word per
// chip write it emits; rsp_last marks the final word of a request, and every
// word reports the eight operator key-on masks as they stand after that write.
// Undefined operations are taken and produce no word.
// Flow: a plain write is registered in the output register when it is
// accepted and appears on the response port in the following cycle. A command
// spends its accepting cycle loading the controller; its first word is then
// formed and registered in the output register, and each further word follows
// as soon as the output register is free. Throughput: plain writes pass at one
// word per cycle while rsp_ready is high. Key-on, key-off and the output off/on
// commands emit 8 words, the level mute and restore commands 32, and the combined
// mute and unmute commands 40, one per cycle while rsp_ready is high. A new
// request is taken only once the controller is idle again, after its sequence
// counter has passed the last word and the single-entry output register is free.
// Stall: when the receiver holds rsp_ready low, the response word waits in the
// output register, the sequence pauses and req_ready stays low.
// Reset: synchronous and active high. It empties the output register, returns
// the controller to idle, holds req_ready low and clears the shadows at once.
module fm_chip_write_shadow_mute_sequencer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fmws_pkg::OP_W-1:0]       req_operation,
   input  logic [fmws_pkg::BYTE_W-1:0]     req_reg_address,
   input  logic [fmws_pkg::BYTE_W-1:0]     req_reg_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fmws_pkg::BYTE_W-1:0]     rsp_bus_address,
   output logic [fmws_pkg::BYTE_W-1:0]     rsp_bus_data,
   output logic                            rsp_last,
   output logic [fmws_pkg::MASK_W-1:0]     rsp_keyon_masks
);
   import fmws_pkg::*;

   // Command from the controller to the datapath, and the datapath's status back.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller decodes requests and counts through each sequence.
   fmws_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the shadows, forms each chip write and registers it.
   fmws_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_reg_address (req_reg_address),
      .req_reg_value   (req_reg_value),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_data    (rsp_bus_data),
      .rsp_last        (rsp_last),
      .rsp_keyon_masks (rsp_keyon_masks)
   );

endmodule

>>> hw/rtl/fmws_checker.sv
// Port-level assertions for the write sequencer, bound to the top level.
// Depends on the ports of fm_chip_write_shadow_mute_sequencer_core.
module fmws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_bus_address,
   input logic [7:0]  rsp_bus_data,
   input logic        rsp_last,
   input logic [31:0] rsp_keyon_masks
);

   // A stalled response word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_address)
         && $stable(rsp_bus_data) && $stable(rsp_last) && $stable(rsp_keyon_masks))
      else $error("response word changed while stalled");

   // No request is taken while the output register is blocked.
   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request ready while response is stalled");

   // A sequence continues without a gap once a non-final word is taken.
   a_seq_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("sequence word missing after non-final word");

   // A key-on register write is already reflected in the reported masks.
   a_mask_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_address == 8'h08 |->
         ((rsp_keyon_masks >> (4 * rsp_bus_data[2:0])) & 32'hF)
            == {28'b0, rsp_bus_data[6:3]})
      else $error("key-on mask does not match the emitted write");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fm_chip_write_shadow_mute_sequencer_core fmws_checker u_fmws_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_bus_address (rsp_bus_address),
   .rsp_bus_data    (rsp_bus_data),
   .rsp_last        (rsp_last),
   .rsp_keyon_masks (rsp_keyon_masks)
);
